### rtl/slt_pkg.sv
// shared types and constants for the sigmoid / tanh table lookup block
// no dependencies; imported by the interfaces and every rtl module
`timescale 1ns / 1ps
`default_nettype none

package slt_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int Q15_W       = 16;
  localparam int FRAC_W      = 4;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;
  // biased sample stays below 2 * (8 << 15) = 2^19
  localparam int BIAS_W      = 20;
  localparam int SHIFT_W     = 4;

  localparam logic [FRAC_W-1:0] FRAC_BITS_RESET = 4'd7;

  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    FUNC_SIGMOID = 1'b0,
    FUNC_TANH    = 1'b1
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAC_BITS   = 1'b0,
    REG_FUNC_SELECT = 1'b1
  } cfg_reg_t;

  localparam logic [4:0] SIGMOID_LIMIT = 5'd8;
  localparam logic [4:0] TANH_LIMIT    = 5'd4;
  localparam logic [4:0] SIGMOID_K     = 5'd7;
  localparam logic [4:0] TANH_K        = 5'd8;

  localparam logic signed [Q15_W-1:0] Q15_MAX     = 16'sh7fff;
  localparam logic signed [Q15_W-1:0] Q15_MIN     = 16'sh8000;
  localparam logic signed [Q15_W-1:0] Q15_ZERO    = 16'sh0000;

  // result of the address stage
  typedef struct packed {
    logic                    sat;
    logic signed [Q15_W-1:0] sat_value;
    logic [ADDR_W-1:0]       addr;
  } lookup_t;

endpackage

`default_nettype wire

### rtl/slt_if.sv
// valid/ready channel interfaces for samples in and activations out
// depends on slt_pkg
`timescale 1ns / 1ps
`default_nettype none

interface slt_in_if #(
  parameter int SAMPLE_WIDTH = 24
) ();
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [SAMPLE_WIDTH-1:0]     sample;
  logic [slt_pkg::ADDR_W-1:0]         entry_index;
  logic signed [slt_pkg::Q15_W-1:0]   entry_value;
  logic                               last_sample;

  modport source (
    output valid, cmd, sample, entry_index, entry_value, last_sample,
    input  ready
  );
  modport sink (
    input  valid, cmd, sample, entry_index, entry_value, last_sample,
    output ready
  );
endinterface

interface slt_out_if ();
  logic                               valid;
  logic                               ready;
  logic signed [slt_pkg::Q15_W-1:0]   activation;
  logic                               last_result;

  modport source (
    output valid, activation, last_result,
    input  ready
  );
  modport sink (
    input  valid, activation, last_result,
    output ready
  );
endinterface

`default_nettype wire

### rtl/slt_index.sv
// range check and table address for one sample
// depends on slt_pkg
`timescale 1ns / 1ps
`default_nettype none

module slt_index #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic signed [SAMPLE_WIDTH-1:0]  sample,
  input  wire logic [slt_pkg::FRAC_W-1:0]      frac_bits,
  input  wire logic                            func_select,
  output slt_pkg::lookup_t                     lookup
);
  import slt_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] limit;
  logic signed [SAMPLE_WIDTH-1:0] neg_limit;
  logic [SAMPLE_WIDTH-1:0]        biased;
  logic [BIAS_W-1:0]              biased_low;
  logic [BIAS_W-1:0]              shifted;
  logic [4:0]                     k;
  logic [4:0]                     frac_ext;
  logic [SHIFT_W-1:0]             rshift;
  logic [SHIFT_W-1:0]             lshift;

  always_comb begin
    limit     = SAMPLE_WIDTH'((func_select == FUNC_TANH) ? TANH_LIMIT : SIGMOID_LIMIT)
                << frac_bits;
    neg_limit = -limit;
    biased    = sample + limit;
    biased_low = biased[BIAS_W-1:0];

    k        = (func_select == FUNC_TANH) ? TANH_K : SIGMOID_K;
    frac_ext = {1'b0, frac_bits};
    if (frac_ext >= k) begin
      rshift = SHIFT_W'(frac_ext - k);
      lshift = '0;
    end else begin
      rshift = '0;
      lshift = SHIFT_W'(k - frac_ext);
    end
    shifted = (biased_low >> rshift) << lshift;

    lookup.addr = shifted[ADDR_W-1:0];
    if (sample >= limit) begin
      lookup.sat       = 1'b1;
      lookup.sat_value = Q15_MAX;
    end else if (sample < neg_limit) begin
      lookup.sat       = 1'b1;
      lookup.sat_value = (func_select == FUNC_TANH) ? Q15_MIN : Q15_ZERO;
    end else begin
      lookup.sat       = 1'b0;
      lookup.sat_value = Q15_ZERO;
    end
  end

endmodule

`default_nettype wire

### rtl/slt_table.sv
// 2048 x 16 activation table, one write port, one registered read port
// depends on slt_pkg
`timescale 1ns / 1ps
`default_nettype none

module slt_table (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [slt_pkg::ADDR_W-1:0]     wr_addr,
  input  wire logic signed [slt_pkg::Q15_W-1:0] wr_data,
  input  wire logic                           rd_en,
  input  wire logic [slt_pkg::ADDR_W-1:0]     rd_addr,
  output logic signed [slt_pkg::Q15_W-1:0]    rd_data
);
  import slt_pkg::*;

  logic signed [Q15_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while the consumer stage is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/sigmoid_tanh_table_lookup.sv
// an evaluate transaction passes through the table read register, then the output register,
// before its result is offered; back-pressure on results can hold it between the two
// throughput: one transaction per cycle while results.ready is high, set by the single table read port
// write transactions store one table word at acceptance and give no result
// rst clears the pipeline valids and sets frac_bits to 7, func_select to sigmoid
// the table is not cleared: entries are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module sigmoid_tanh_table_lookup #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  slt_in_if.sink                                   samples,
  slt_out_if.source                                results,
  input  wire logic                                cfg_we,
  input  wire logic [slt_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [slt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import slt_pkg::*;

  logic [FRAC_W-1:0]       frac_bits;
  logic                    func_select;

  lookup_t                 lookup;
  logic                    in_accept;
  logic                    wr_en;
  logic                    rd_en;
  logic signed [Q15_W-1:0] rd_data;

  logic                    s1_valid;
  logic                    s1_valid_next;
  logic                    s1_sat;
  logic signed [Q15_W-1:0] s1_sat_value;
  logic                    s1_last;

  logic                    out_valid;
  logic                    out_valid_next;
  logic signed [Q15_W-1:0] out_activation;
  logic                    out_last;
  logic                    out_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits   <= FRAC_BITS_RESET;
      func_select <= FUNC_SIGMOID;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAC_BITS:   frac_bits   <= cfg_data[FRAC_W-1:0];
        REG_FUNC_SELECT: func_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  slt_index #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_index (
    .sample      (samples.sample),
    .frac_bits   (frac_bits),
    .func_select (func_select),
    .lookup      (lookup)
  );

  assign in_accept = samples.valid & samples.ready;
  assign wr_en     = in_accept & (samples.cmd == CMD_WRITE);
  assign rd_en     = in_accept & (samples.cmd == CMD_EVAL);

  slt_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (samples.entry_index),
    .wr_data (samples.entry_value),
    .rd_en   (rd_en),
    .rd_addr (lookup.addr),
    .rd_data (rd_data)
  );

  // pipeline control: stage 1 waits on the table read, then the output register
  assign out_load      = s1_valid & (~out_valid | results.ready);
  assign samples.ready = ~s1_valid | out_load;

  always_comb begin
    if (in_accept) begin
      s1_valid_next = (samples.cmd == CMD_EVAL);
    end else if (out_load) begin
      s1_valid_next = 1'b0;
    end else begin
      s1_valid_next = s1_valid;
    end

    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (results.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_sat       <= lookup.sat;
      s1_sat_value <= lookup.sat_value;
      s1_last      <= samples.last_sample;
    end
    if (out_load) begin
      out_activation <= s1_sat ? s1_sat_value : rd_data;
      out_last       <= s1_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.activation  = out_activation;
  assign results.last_result = out_last;

endmodule

`default_nettype wire
